FILE: hdl/sha1mh_pkg.sv
// Package for the SHA-1 message hasher: payload words, control and status
// structs, round constants and the microcode table. No dependencies.
package sha1mh_pkg;

  // Payload words
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  // Hash constants
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [31:0] IV_0 = 32'h67452301;
  localparam logic [31:0] IV_1 = 32'hefcdab89;
  localparam logic [31:0] IV_2 = 32'h98badcfe;
  localparam logic [31:0] IV_3 = 32'h10325476;
  localparam logic [31:0] IV_4 = 32'hc3d2e1f0;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  // Microcode step addresses
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT  = 4'd0;
  localparam step_t STEP_PAD80 = 4'd1;
  localparam step_t STEP_ZERO  = 4'd2;
  localparam step_t STEP_LEN   = 4'd3;
  localparam step_t STEP_OUT   = 4'd4;
  localparam step_t STEP_INIT  = 4'd5;
  localparam step_t STEP_LOADW = 4'd6;
  localparam step_t STEP_ROUND = 4'd7;
  localparam step_t STEP_ADDCV = 4'd8;

  // Byte source for the block buffer
  typedef enum logic [4:0] {
    BSEL_NONE  = 5'b00001,
    BSEL_MSG   = 5'b00010,
    BSEL_PAD80 = 5'b00100,
    BSEL_ZERO  = 5'b01000,
    BSEL_LEN   = 5'b10000
  } byte_sel_t;

  // Next-step rule
  typedef enum logic [7:0] {
    COND_NEXT  = 8'b00000001,  // pc + 1
    COND_GOTO  = 8'b00000010,  // target
    COND_WAIT  = 8'b00000100,  // target on accepted word that ends message
    COND_PAD   = 8'b00001000,  // target once fill reaches 56
    COND_LEN   = 8'b00010000,  // target after the last length byte
    COND_ROUND = 8'b00100000,  // target after round 79
    COND_EMIT  = 8'b01000000,  // target after the fifth digest word
    COND_RET   = 8'b10000000   // return from compression
  } cond_t;

  typedef struct packed {
    logic      ready;
    byte_sel_t byte_sel;
    logic      latch_len;
    logic      load_work;
    logic      round_en;
    logic      add_cv;
    logic      emit;
    logic      init;
    cond_t     cond;
    step_t     target;
  } ucode_word_t;

  // Strobes from sequencer to datapath
  typedef struct packed {
    logic      absorb;
    byte_sel_t byte_sel;
    logic      latch_len;
    logic      load_work;
    logic      round_en;
    logic      add_cv;
    logic      emit;
    logic      init;
  } ctrl_t;

  // Flags from datapath to sequencer
  typedef struct packed {
    logic pos_is_56;
    logic pos_is_63;
    logic round_last;
    logic word_last;
    logic out_free;
  } status_t;

  function automatic ucode_word_t cw(input logic ready, input byte_sel_t bsel,
                                     input logic latch_len, input logic load_work,
                                     input logic round_en, input logic add_cv,
                                     input logic emit, input logic init,
                                     input cond_t cond, input step_t target);
    ucode_word_t w;
    w.ready     = ready;
    w.byte_sel  = bsel;
    w.latch_len = latch_len;
    w.load_work = load_work;
    w.round_en  = round_en;
    w.add_cv    = add_cv;
    w.emit      = emit;
    w.init      = init;
    w.cond      = cond;
    w.target    = target;
    return w;
  endfunction

  // Microcode program; compression is a subroutine entered on a full block
  function automatic ucode_word_t ucode_rom(input step_t pc);
    ucode_word_t w;
    unique case (pc)
      STEP_WAIT:  w = cw(1'b1, BSEL_MSG,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                         COND_WAIT, STEP_PAD80);
      STEP_PAD80: w = cw(1'b0, BSEL_PAD80, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                         COND_NEXT, STEP_ZERO);
      STEP_ZERO:  w = cw(1'b0, BSEL_ZERO,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                         COND_PAD, STEP_LEN);
      STEP_LEN:   w = cw(1'b0, BSEL_LEN,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                         COND_LEN, STEP_OUT);
      STEP_OUT:   w = cw(1'b0, BSEL_NONE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                         COND_EMIT, STEP_INIT);
      STEP_INIT:  w = cw(1'b0, BSEL_NONE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                         COND_GOTO, STEP_WAIT);
      STEP_LOADW: w = cw(1'b0, BSEL_NONE,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                         COND_NEXT, STEP_ROUND);
      STEP_ROUND: w = cw(1'b0, BSEL_NONE,  1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                         COND_ROUND, STEP_ADDCV);
      STEP_ADDCV: w = cw(1'b0, BSEL_NONE,  1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                         COND_RET, STEP_WAIT);
      default:    w = cw(1'b0, BSEL_NONE,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                         COND_GOTO, STEP_WAIT);
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/sha1mh_sequencer.sv
// Microcode sequencer: step counter, return register and table lookup.
// Depends on sha1mh_pkg.
module sha1mh_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  input  logic               has_byte,
  input  logic               end_of_message,
  input  sha1mh_pkg::status_t status,
  output logic               msg_ready,
  output sha1mh_pkg::ctrl_t   ctrl
);
  import sha1mh_pkg::*;

  step_t       pc;
  step_t       pc_next;
  step_t       ret_pc;
  step_t       seq_next;
  ucode_word_t word;
  logic        accept;
  logic        emit_go;

  // No word is taken while reset is held
  assign word      = ucode_rom(pc);
  assign msg_ready = word.ready & ~rst;
  assign accept    = msg_ready & msg_valid;
  assign emit_go   = word.emit & status.out_free;

  // Qualify the control word with the live flags
  always_comb begin
    ctrl.byte_sel  = word.byte_sel;
    ctrl.latch_len = word.latch_len;
    ctrl.load_work = word.load_work;
    ctrl.round_en  = word.round_en;
    ctrl.add_cv    = word.add_cv;
    ctrl.emit      = emit_go;
    ctrl.init      = word.init;
    unique case (word.byte_sel)
      BSEL_MSG:   ctrl.absorb = accept & has_byte;
      BSEL_PAD80: ctrl.absorb = 1'b1;
      BSEL_ZERO:  ctrl.absorb = ~status.pos_is_56;
      BSEL_LEN:   ctrl.absorb = 1'b1;
      default:    ctrl.absorb = 1'b0;
    endcase
  end

  // Next step from the word's jump rule
  always_comb begin
    unique case (word.cond)
      COND_NEXT:  seq_next = pc + step_t'(1);
      COND_GOTO:  seq_next = word.target;
      COND_WAIT:  seq_next = (accept & end_of_message) ? word.target : pc;
      COND_PAD:   seq_next = status.pos_is_56 ? word.target : pc;
      COND_LEN:   seq_next = status.pos_is_63 ? word.target : pc;
      COND_ROUND: seq_next = status.round_last ? word.target : pc;
      COND_EMIT:  seq_next = (emit_go & status.word_last) ? word.target : pc;
      COND_RET:   seq_next = ret_pc;
      default:    seq_next = STEP_WAIT;
    endcase
  end

  // A byte landing in the last slot calls the compression routine
  assign pc_next = (ctrl.absorb & status.pos_is_63) ? STEP_LOADW : seq_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= STEP_WAIT;
      ret_pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
      if (ctrl.absorb & status.pos_is_63) begin
        ret_pc <= seq_next;
      end
    end
  end

endmodule

FILE: hdl/sha1mh_datapath.sv
// Datapath: block buffer / schedule line, working registers, chaining value,
// bit count and the digest output register. Depends on sha1mh_pkg.
module sha1mh_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              msg_byte,
  input  sha1mh_pkg::ctrl_t        ctrl,
  output sha1mh_pkg::status_t      status,
  output logic                    digest_valid,
  input  logic                    digest_ready,
  output sha1mh_pkg::digest_word_t digest
);
  import sha1mh_pkg::*;

  logic [511:0] wline;      // 16 words, word 0 in the top bits
  logic [31:0]  cv [5];
  logic [31:0]  a, b, c, d, e;
  logic [63:0]  bit_length;
  logic [63:0]  len_reg;
  logic [63:0]  len_shift;
  logic [6:0]   round_t;
  logic [2:0]   widx;
  logic [5:0]   pos;
  logic [7:0]   byte_in;
  logic [31:0]  wt;
  logic [31:0]  mix;
  logic [31:0]  f;
  logic [31:0]  k;
  logic [31:0]  tmp;

  assign pos       = bit_length[8:3];
  assign len_shift = len_reg >> {~pos[2:0], 3'b000};

  assign status.pos_is_56  = (pos == 6'd56);
  assign status.pos_is_63  = (pos == 6'd63);
  assign status.round_last = (round_t == ROUND_LAST);
  assign status.word_last  = (widx == WORD_LAST);
  assign status.out_free   = ~digest_valid | digest_ready;

  // Byte into the buffer
  always_comb begin
    unique case (ctrl.byte_sel)
      BSEL_MSG:   byte_in = msg_byte;
      BSEL_PAD80: byte_in = PAD_BYTE;
      BSEL_LEN:   byte_in = len_shift[7:0];
      default:    byte_in = 8'h00;
    endcase
  end

  // Schedule word: first 16 rounds rotate the loaded block through
  assign mix = wline[511-32*13 -: 32] ^ wline[511-32*8 -: 32]
             ^ wline[511-32*2 -: 32] ^ wline[511 -: 32];
  assign wt  = (round_t < 7'd16) ? wline[511 -: 32] : {mix[30:0], mix[31]};

  // Round function and constant
  always_comb begin
    if (round_t < 7'd20) begin
      f = d ^ (b & (c ^ d));
      k = K_0;
    end else if (round_t < 7'd40) begin
      f = b ^ c ^ d;
      k = K_1;
    end else if (round_t < 7'd60) begin
      f = (b & c) | (d & (b | c));
      k = K_2;
    end else begin
      f = b ^ c ^ d;
      k = K_3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + k + wt;

  // Buffer line and working registers
  always_ff @(posedge clk) begin
    if (ctrl.absorb) begin
      wline <= {wline[503:0], byte_in};
    end else if (ctrl.round_en) begin
      wline <= {wline[479:0], wt};
    end
    if (ctrl.latch_len) begin
      len_reg <= bit_length;
    end
    if (ctrl.load_work) begin
      a <= cv[0];
      b <= cv[1];
      c <= cv[2];
      d <= cv[3];
      e <= cv[4];
    end else if (ctrl.round_en) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= tmp;
    end
  end

  // Round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      round_t <= '0;
    end else if (ctrl.load_work) begin
      round_t <= '0;
    end else if (ctrl.round_en) begin
      round_t <= round_t + 7'd1;
    end
  end

  // Chaining value and bit count; emit rotates words out of slot 0
  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      cv[0]      <= IV_0;
      cv[1]      <= IV_1;
      cv[2]      <= IV_2;
      cv[3]      <= IV_3;
      cv[4]      <= IV_4;
      bit_length <= '0;
    end else begin
      if (ctrl.absorb) begin
        bit_length <= bit_length + 64'd8;
      end
      if (ctrl.add_cv) begin
        cv[0] <= cv[0] + a;
        cv[1] <= cv[1] + b;
        cv[2] <= cv[2] + c;
        cv[3] <= cv[3] + d;
        cv[4] <= cv[4] + e;
      end else if (ctrl.emit) begin
        cv[0] <= cv[1];
        cv[1] <= cv[2];
        cv[2] <= cv[3];
        cv[3] <= cv[4];
        cv[4] <= cv[0];
      end
    end
  end

  // Digest output register
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
      widx         <= '0;
    end else if (ctrl.emit) begin
      digest_valid <= 1'b1;
      widx         <= status.word_last ? 3'd0 : widx + 3'd1;
    end else if (digest_ready) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      digest.digest_word <= cv[0];
      digest.word_index  <= widx;
      digest.last_word   <= status.word_last;
    end
  end

endmodule

FILE: hdl/sha1_message_hasher_top.sv
// SHA-1 message hasher, one message byte per input word, five digest words
// per message. Uses sha1mh_pkg, sha1mh_sequencer and sha1mh_datapath.
//
// Input channel msg (valid/ready): each word carries an optional byte and
// an end-of-message flag, and msg_ready stays high between bytes. When the
// 64-byte block fills, msg_ready drops while the compression runs (load,
// 80 rounds at one per cycle, chaining add), so no new byte is taken until
// the compression is done, and the round loop sets the byte rate.
// End of message: the sequencer pads one byte per cycle, pausing while a
// compression runs (0x80, zeros to offset 56, eight length bytes),
// compresses once or twice, then loads the five digest words into the
// output register, one per cycle while it is free, and restores the
// initial chaining value and count.
// Output channel digest (valid/ready): a single output register; while the
// receiver stalls, the sequencer holds at the word that waits, and msg
// accepts again after the init step that follows the last digest word.
// Reset (rst, synchronous) restores the initial chaining value, clears the
// count and the output valid flag; msg_ready is low while rst is held.
module sha1_message_hasher_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     msg_valid,
  output logic                     msg_ready,
  input  sha1mh_pkg::msg_word_t    msg,
  output logic                     digest_valid,
  input  logic                     digest_ready,
  output sha1mh_pkg::digest_word_t digest
);
  import sha1mh_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  sha1mh_sequencer u_seq (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .has_byte       (msg.has_byte),
    .end_of_message (msg.end_of_message),
    .status         (status),
    .msg_ready      (msg_ready),
    .ctrl           (ctrl)
  );

  sha1mh_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .msg_byte     (msg.msg_byte),
    .ctrl         (ctrl),
    .status       (status),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

endmodule
